>>> sv/ordered_array_table_engine_unit_defines.svh
// assertion macros for the ordered array table engine
`ifndef ORDERED_ARRAY_TABLE_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OATE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OATE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OATE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OATE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/oate_pkg.sv
`default_nettype none
package oate_pkg;
    localparam int Depth = 32;
    localparam int IdxW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    localparam logic [2:0] MODE_INS  = 3'd0;
    localparam logic [2:0] MODE_DEL  = 3'd1;
    localparam logic [2:0] MODE_LIN  = 3'd2;
    localparam logic [2:0] MODE_BIN  = 3'd3;
    localparam logic [2:0] MODE_DUMP = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE, CMD_LOAD, CMD_RD, CMD_SHUP, CMD_SHDN, CMD_WRVAL, CMD_SWAP
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [IdxW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [31:0] rdata;
    } t_stat;
endpackage
`default_nettype wire

>>> sv/oate_datapath.sv
`default_nettype none
module oate_datapath (
    input  wire logic          i_clk,
    input  wire oate_pkg::t_cmd  i_cmd,
    input  wire logic [31:0]   i_value,
    output oate_pkg::t_stat    o_stat
);
    import oate_pkg::*;

    logic [31:0] r_mem [Depth];
    logic [31:0] r_rdata;
    logic [31:0] r_hold;

    // single-port style table: one read or write per cycle, registered read
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_RD: begin
                r_rdata <= r_mem[i_cmd.addr];
            end
            CMD_LOAD: begin
                r_hold <= r_mem[i_cmd.addr];
                r_rdata <= r_mem[i_cmd.addr];
            end
            CMD_SHUP, CMD_SHDN: begin
                r_mem[i_cmd.addr] <= r_rdata;
            end
            CMD_WRVAL: begin
                r_mem[i_cmd.addr] <= i_value;
            end
            CMD_SWAP: begin
                r_mem[i_cmd.addr] <= r_hold;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.rdata = r_rdata;
endmodule
`default_nettype wire

>>> sv/oate_ctrl.sv
`default_nettype none
module oate_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire logic [2:0]           i_mode,
    input  wire logic [31:0]          i_value,
    input  wire logic [5:0]           i_position,
    input  wire logic                 i_out_ready,
    input  wire oate_pkg::t_stat      i_stat,
    output oate_pkg::t_cmd            o_cmd,
    output logic                      o_busy,
    output logic                      o_out_valid,
    output logic [1:0]                o_status,
    output logic [4:0]                o_index,
    output logic [31:0]               o_value_out,
    output logic [5:0]                o_count,
    output logic                      o_last
);
    import oate_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR, S_LIN_RD, S_LIN_CMP,
        S_SRT_LD, S_SRT_RD, S_SRT_CMP, S_BIN_RD, S_BIN_CMP, S_DMP_RD, S_DMP_OUT,
        S_OUT, S_RD_WAIT
    } t_state;

    t_state            r_state;
    t_state            r_ret;
    logic [2:0]        r_mode;
    logic [31:0]       r_val;
    logic [31:0]       r_key;
    logic [CntW-1:0]   r_pos;
    logic [CntW-1:0]   r_cnt;
    logic [CntW-1:0]   r_i;
    logic [CntW-1:0]   r_j;
    logic [CntW:0]     r_lo;
    logic [CntW:0]     r_hi;
    logic [1:0]        r_status;
    logic [IdxW-1:0]   r_index;
    logic [31:0]       r_vout;
    logic              r_last;
    logic              r_valid;
    t_cmd              r_cmd;

    logic [CntW:0]     w_mid;
    logic              w_lt;
    logic              w_key_lt;

    assign w_mid    = (r_lo + r_hi) >> 1;
    assign w_lt     = $signed(i_stat.rdata) < $signed(r_val);
    // key held in r_key during the insertion sort
    assign w_key_lt = $signed(r_key) < $signed(i_stat.rdata);

    // sequencer: at most one table access per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_cmd   <= '{op: CMD_NONE, addr: '0};
        end else begin
            r_cmd <= '{op: CMD_NONE, addr: '0};
            case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_mode   <= i_mode;
                        r_val    <= i_value;
                        r_pos    <= i_position[CntW-1:0];
                        r_status <= ST_OK;
                        r_index  <= '0;
                        r_vout   <= '0;
                        r_last   <= 1'b1;
                        r_state  <= S_OUT;
                        case (i_mode)
                            MODE_INS: begin
                                if (r_cnt >= CntW'(Depth) ||
                                    {1'b0, i_position} > 7'(r_cnt)) begin
                                    r_status <= ST_BAD;
                                end else if (7'(i_position) == 7'(r_cnt)) begin
                                    r_cmd   <= '{op: CMD_WRVAL,
                                                 addr: i_position[IdxW-1:0]};
                                    r_cnt   <= r_cnt + 1'b1;
                                end else begin
                                    r_i     <= r_cnt;
                                    r_cmd   <= '{op: CMD_RD,
                                                 addr: IdxW'(r_cnt - 1'b1)};
                                    r_state <= S_INS_WR;
                                end
                            end
                            MODE_DEL: begin
                                if (7'(i_position) >= 7'(r_cnt)) begin
                                    r_status <= ST_BAD;
                                end else begin
                                    r_i     <= i_position[CntW-1:0];
                                    r_state <= S_DEL_RD;
                                end
                            end
                            MODE_LIN: begin
                                r_i     <= '0;
                                r_state <= S_LIN_RD;
                            end
                            MODE_BIN: begin
                                r_i     <= CntW'(1);
                                r_state <= S_SRT_LD;
                            end
                            MODE_DUMP: begin
                                if (r_cnt == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_i     <= '0;
                                    r_state <= S_DMP_RD;
                                end
                            end
                            default: r_status <= ST_BAD;
                        endcase
                    end
                end
                // registered table read lands in the cycle after the command
                S_RD_WAIT: begin
                    r_state <= r_ret;
                end
                // insert: move entry i-1 to i, down to the position
                S_INS_RD: begin
                    r_cmd   <= '{op: CMD_RD, addr: IdxW'(r_i - 1'b1)};
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_cmd <= '{op: CMD_SHUP, addr: IdxW'(r_i)};
                    if (r_i - 1'b1 == r_pos) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_INS_RD;
                    end
                end
                // delete: move entry i+1 to i; reuse S_DEL_WR as insert finish
                S_DEL_RD: begin
                    if (r_mode == MODE_DEL && r_i + 1'b1 >= r_cnt) begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_cmd   <= '{op: CMD_RD, addr: IdxW'(r_i + 1'b1)};
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    if (r_mode == MODE_DEL) begin
                        r_cmd   <= '{op: CMD_SHDN, addr: IdxW'(r_i)};
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DEL_RD;
                    end else begin
                        r_cmd   <= '{op: CMD_WRVAL, addr: IdxW'(r_pos)};
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_OUT;
                    end
                end
                // linear scan
                S_LIN_RD: begin
                    if (r_i >= r_cnt) begin
                        r_status <= ST_MISS;
                        r_state  <= S_OUT;
                    end else begin
                        r_cmd   <= '{op: CMD_RD, addr: IdxW'(r_i)};
                        r_ret   <= S_LIN_CMP;
                        r_state <= S_RD_WAIT;
                    end
                end
                S_LIN_CMP: begin
                    if (i_stat.rdata == r_val) begin
                        r_index <= IdxW'(r_i);
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_LIN_RD;
                    end
                end
                // insertion sort: key kept in the datapath hold register
                S_SRT_LD: begin
                    if (r_i >= r_cnt) begin
                        r_lo    <= '0;
                        r_hi    <= (CntW+1)'(r_cnt) - 1'b1;
                        r_state <= S_BIN_RD;
                    end else begin
                        r_cmd   <= '{op: CMD_LOAD, addr: IdxW'(r_i)};
                        r_j     <= r_i;
                        r_ret   <= S_SRT_RD;
                        r_state <= S_RD_WAIT;
                    end
                end
                S_SRT_RD: begin
                    if (r_j == '0) begin
                        r_cmd   <= '{op: CMD_SWAP, addr: '0};
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRT_LD;
                    end else begin
                        if (r_j == r_i) r_key <= i_stat.rdata;
                        r_cmd   <= '{op: CMD_RD, addr: IdxW'(r_j - 1'b1)};
                        r_ret   <= S_SRT_CMP;
                        r_state <= S_RD_WAIT;
                    end
                end
                S_SRT_CMP: begin
                    if (w_key_lt) begin
                        r_cmd   <= '{op: CMD_SHUP, addr: IdxW'(r_j)};
                        r_j     <= r_j - 1'b1;
                        r_state <= S_SRT_RD;
                    end else begin
                        r_cmd   <= '{op: CMD_SWAP, addr: IdxW'(r_j)};
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRT_LD;
                    end
                end
                // binary search for r_val
                S_BIN_RD: begin
                    if ($signed(r_lo) > $signed(r_hi)) begin
                        r_status <= ST_MISS;
                        r_state  <= S_OUT;
                    end else begin
                        r_cmd   <= '{op: CMD_RD, addr: IdxW'(w_mid)};
                        r_ret   <= S_BIN_CMP;
                        r_state <= S_RD_WAIT;
                    end
                end
                S_BIN_CMP: begin
                    if (i_stat.rdata == r_val) begin
                        r_index <= IdxW'(w_mid);
                        r_state <= S_OUT;
                    end else if (w_lt) begin
                        r_lo    <= w_mid + 1'b1;
                        r_state <= S_BIN_RD;
                    end else begin
                        r_hi    <= w_mid - 1'b1;
                        r_state <= S_BIN_RD;
                    end
                end
                // dump
                S_DMP_RD: begin
                    r_cmd   <= '{op: CMD_RD, addr: IdxW'(r_i)};
                    r_ret   <= S_DMP_OUT;
                    r_state <= S_RD_WAIT;
                end
                S_DMP_OUT: begin
                    r_index <= IdxW'(r_i);
                    r_vout  <= i_stat.rdata;
                    r_last  <= (r_i + 1'b1 == r_cnt);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                    end else if (i_out_ready) begin
                        r_valid <= 1'b0;
                        if (r_mode == MODE_DUMP && !r_last) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_DMP_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd       = r_cmd;
    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_valid;
    assign o_status    = r_status;
    assign o_index     = 5'(r_index);
    assign o_value_out = r_vout;
    assign o_count     = 6'(r_cnt);
    assign o_last      = r_last;
endmodule
`default_nettype wire

>>> sv/ordered_array_table_engine_unit.sv
// ordered array table engine: one transaction in flight, input ready again the cycle
// after the last result is taken; each result is registered in S_OUT before valid rises
// insert/delete: a read and a write per moved entry; linear search: read, wait, compare
// per entry; sort-search: insertion sort, then binary search probes of read, wait, compare
// dump: read, wait, output per entry; reset clears count and control, keeps the table
`default_nettype none
`include "ordered_array_table_engine_unit_defines.svh"
module ordered_array_table_engine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // mode[2:0], value[34:3], position[40:35]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // status[1:0], index[6:2], value_out[38:7],
                                            // count[44:39]
    output logic             m_axis_tlast
);
    import oate_pkg::*;

    t_cmd        w_cmd;
    t_stat       w_stat;
    logic        w_busy;
    logic [1:0]  w_status;
    logic [4:0]  w_index;
    logic [31:0] w_vout;
    logic [5:0]  w_count;
    logic        w_go;
    logic [31:0] w_dp_val;

    assign s_axis_tready = !w_busy;
    assign w_go          = s_axis_tvalid && s_axis_tready;
    assign w_dp_val      = s_axis_tdata[34:3];

    oate_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_mode      (s_axis_tdata[2:0]),
        .i_value     (s_axis_tdata[34:3]),
        .i_position  (s_axis_tdata[40:35]),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (w_busy),
        .o_out_valid (m_axis_tvalid),
        .o_status    (w_status),
        .o_index     (w_index),
        .o_value_out (w_vout),
        .o_count     (w_count),
        .o_last      (m_axis_tlast)
    );

    logic [31:0] r_inval;
    // hold the insert value for the write after shifting
    always_ff @(posedge i_clk) begin
        if (w_go) r_inval <= w_dp_val;
    end

    oate_datapath u_dp (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_value (w_go ? w_dp_val : r_inval),
        .o_stat  (w_stat)
    );

    assign m_axis_tdata = {3'b000, w_count, w_vout, w_index, w_status};

    `OATE_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `OATE_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, w_count <= 6'(Depth))
    `OATE_ASSERT_NEXT(a_busy_after_go, i_clk, i_rst_n, w_go, !s_axis_tready)
endmodule
`default_nettype wire
